// ===== rtl/core/qfrm_pkg.sv =====
// Package for the rotation matrix to quaternion unit: widths, slot codes, pipeline word.
`default_nettype none
package qfrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int OP_W      = IN_W + 1;
  localparam int RAD_W     = (FRAC_BITS + 2 > IN_W + 2) ? FRAC_BITS + 2 : IN_W + 2;
  localparam int RADU_W    = RAD_W - 1;
  localparam int V_W       = RADU_W + FRAC_BITS;
  localparam int ROOT_W    = (V_W + 1) / 2;
  localparam int HALF_W    = ROOT_W - 1;
  localparam int SQ_PAD    = 2 * ROOT_W;
  localparam int SR_W      = ROOT_W + 2;
  localparam int SRN_W     = SR_W + 2;
  localparam int REC_W     = 2 * FRAC_BITS;
  localparam int PROD_W    = OP_W + REC_W;
  localparam int SCL_W     = PROD_W - FRAC_BITS;
  localparam int SQ_ST     = (ROOT_W + 1) / 2;
  localparam int DIV_ST    = (REC_W + 1) / 2;
  localparam int NST       = 1 + SQ_ST + DIV_ST;

  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  typedef struct packed {
    slot_t                             slot;
    logic                              diag;
    logic signed [3:0][OP_W-1:0]       ops;
    logic [SQ_PAD-1:0]                 vsh;
    logic [SR_W-1:0]                   srem;
    logic [ROOT_W-1:0]                 root;
    logic [ROOT_W-1:0]                 drem;
    logic [REC_W-1:0]                  quo;
  } pipe_t;

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_from_rotation_matrix_unit.sv =====
// Top level: pipelined rotation matrix to unit quaternion conversion.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_stall  | m00 m01 m02 m10 m11 m12 m20 m21 m22 (Q2.14)
//  out     | out_valid, out_stall| quat_w quat_x quat_y quat_z (Q2.14), degenerate
//
// One word enters every cycle unless the output stalls; the pipeline holds, in order,
// one setup stage, the square root at two result bits per stage, the restoring
// reciprocal at two quotient bits per stage, one multiply stage and one output stage.
// rst is synchronous and clears all valid bits; payload registers are not reset.
// A stall on out with a word waiting freezes the whole pipeline and raises in_stall;
// every word holds in place, so none is dropped or repeated.
`default_nettype none
module quaternion_from_rotation_matrix_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m00,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m01,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m02,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m10,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m11,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m12,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m20,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m21,
  input  wire logic signed [qfrm_pkg::IN_W-1:0]  m22,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [qfrm_pkg::OUT_W-1:0]      quat_w,
  output logic signed [qfrm_pkg::OUT_W-1:0]      quat_x,
  output logic signed [qfrm_pkg::OUT_W-1:0]      quat_y,
  output logic signed [qfrm_pkg::OUT_W-1:0]      quat_z,
  output logic                                   degenerate
);

  localparam int NST = qfrm_pkg::NST;

  // Advance everything unless the output word is waiting on a stall.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  qfrm_pkg::pipe_t pipe [NST];
  qfrm_pkg::pipe_t nxt  [NST];
  logic            vld  [NST];

  // Setup stage: trace, path choice, radicand and the four lane operands.
  always_comb begin
    logic signed [qfrm_pkg::RAD_W-1:0] d00, d11, d22, trace, one, rad;
    logic signed [qfrm_pkg::OP_W-1:0]  e01, e02, e10, e12, e20, e21;
    logic [1:0]                        isel;
    logic [qfrm_pkg::RADU_W-1:0]       radu;
    qfrm_pkg::pipe_t                   p;
    d00   = qfrm_pkg::RAD_W'(m00);
    d11   = qfrm_pkg::RAD_W'(m11);
    d22   = qfrm_pkg::RAD_W'(m22);
    e01   = qfrm_pkg::OP_W'(m01);
    e02   = qfrm_pkg::OP_W'(m02);
    e10   = qfrm_pkg::OP_W'(m10);
    e12   = qfrm_pkg::OP_W'(m12);
    e20   = qfrm_pkg::OP_W'(m20);
    e21   = qfrm_pkg::OP_W'(m21);
    one   = qfrm_pkg::RAD_W'(1) <<< qfrm_pkg::FRAC_BITS;
    trace = d00 + d11 + d22;
    // Ties on the diagonal keep the lower index.
    isel = 2'd0;
    if (m11 > m00) isel = 2'd1;
    if ((isel == 2'd0) ? (m22 > m00) : (m22 > m11)) isel = 2'd2;
    p = '0;
    if (trace > 0) begin
      p.diag   = 1'b0;
      p.slot   = qfrm_pkg::SLOT_W;
      rad      = trace + one;
      p.ops[1] = e12 - e21;
      p.ops[2] = e20 - e02;
      p.ops[3] = e01 - e10;
    end else begin
      p.diag = 1'b1;
      case (isel)
        2'd0: begin
          p.slot   = qfrm_pkg::SLOT_X;
          rad      = d00 - (d11 + d22) + one;
          p.ops[0] = e12 - e21;
          p.ops[2] = e01 + e10;
          p.ops[3] = e02 + e20;
        end
        2'd1: begin
          p.slot   = qfrm_pkg::SLOT_Y;
          rad      = d11 - (d22 + d00) + one;
          p.ops[0] = e20 - e02;
          p.ops[3] = e12 + e21;
          p.ops[1] = e10 + e01;
        end
        default: begin
          p.slot   = qfrm_pkg::SLOT_Z;
          rad      = d22 - (d00 + d11) + one;
          p.ops[0] = e01 - e10;
          p.ops[1] = e20 + e02;
          p.ops[2] = e21 + e12;
        end
      endcase
    end
    // Clamp a negative radicand to zero.
    radu  = rad[qfrm_pkg::RAD_W-1] ? '0 : rad[qfrm_pkg::RADU_W-1:0];
    p.vsh = qfrm_pkg::SQ_PAD'({radu, {qfrm_pkg::FRAC_BITS{1'b0}}});
    nxt[0] = p;
  end

  // Root stages then reciprocal stages, two bit steps each.
  for (genvar s = 1; s < NST; s++) begin : g_stage
    always_comb begin
      qfrm_pkg::pipe_t              p;
      logic [qfrm_pkg::SRN_W-1:0]   rn;
      logic [qfrm_pkg::SRN_W-1:0]   tr;
      logic [qfrm_pkg::ROOT_W:0]    dn;
      p  = pipe[s-1];
      rn = '0;
      tr = '0;
      dn = '0;
      for (int t = 0; t < 2; t++) begin
        if (s <= qfrm_pkg::SQ_ST) begin
          if ((s - 1) * 2 + t < qfrm_pkg::ROOT_W) begin
            rn    = {p.srem, p.vsh[qfrm_pkg::SQ_PAD-1 -: 2]};
            tr    = qfrm_pkg::SRN_W'({p.root, 2'b01});
            p.vsh = p.vsh << 2;
            if (rn >= tr) begin
              p.srem = qfrm_pkg::SR_W'(rn - tr);
              p.root = {p.root[qfrm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
              p.srem = qfrm_pkg::SR_W'(rn);
              p.root = {p.root[qfrm_pkg::ROOT_W-2:0], 1'b0};
            end
          end
        end else if ((s - 1 - qfrm_pkg::SQ_ST) * 2 + t < qfrm_pkg::REC_W) begin
          // Dividend is a single one at the top quotient bit.
          dn = {p.drem, ((s - 1 - qfrm_pkg::SQ_ST) * 2 + t == 0)};
          if (dn >= {1'b0, p.root}) begin
            p.drem = qfrm_pkg::ROOT_W'(dn - {1'b0, p.root});
            p.quo  = {p.quo[qfrm_pkg::REC_W-2:0], 1'b1};
          end else begin
            p.drem = dn[qfrm_pkg::ROOT_W-1:0];
            p.quo  = {p.quo[qfrm_pkg::REC_W-2:0], 1'b0};
          end
        end
      end
      nxt[s] = p;
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[s] <= nxt[s];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // Multiply stage: magnitude times reciprocal, scaled down.
  logic                          mvld;
  logic                          mdeg;
  qfrm_pkg::slot_t               mslot;
  logic [qfrm_pkg::HALF_W-1:0]   mhalf;
  logic [3:0]                    mneg;
  logic [qfrm_pkg::SCL_W-1:0]    mp [4];

  always_ff @(posedge clk) begin
    logic [qfrm_pkg::REC_W-1:0]  rc;
    logic [qfrm_pkg::OP_W-1:0]   mag;
    logic [qfrm_pkg::PROD_W-1:0] prod;
    rc = (pipe[NST-1].root == '0) ? '0 : pipe[NST-1].quo;
    if (adv) begin
      mdeg  <= pipe[NST-1].diag && (pipe[NST-1].root == '0);
      mslot <= pipe[NST-1].slot;
      mhalf <= pipe[NST-1].root[qfrm_pkg::ROOT_W-1:1];
      for (int l = 0; l < 4; l++) begin
        mag  = pipe[NST-1].ops[l][qfrm_pkg::OP_W-1] ? qfrm_pkg::OP_W'(-pipe[NST-1].ops[l])
                                                   : qfrm_pkg::OP_W'(pipe[NST-1].ops[l]);
        prod = qfrm_pkg::PROD_W'(mag) * qfrm_pkg::PROD_W'(rc);
        mneg[l] <= pipe[NST-1].ops[l][qfrm_pkg::OP_W-1];
        mp[l]   <= prod[qfrm_pkg::PROD_W-1:qfrm_pkg::FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
    end else if (adv) begin
      mvld <= vld[NST-1];
    end
  end

  // Output stage: saturate each lane and place the half root in its slot.
  logic signed [qfrm_pkg::OUT_W-1:0] lane [4];
  logic signed [qfrm_pkg::OUT_W-1:0] half_sat;

  always_comb begin
    half_sat = (32'(mhalf) > 32'd32767) ? 16'sd32767 : qfrm_pkg::OUT_W'(32'(mhalf));
    for (int l = 0; l < 4; l++) begin
      if (mslot == qfrm_pkg::slot_t'(2'(l))) begin
        lane[l] = half_sat;
      end else if (mneg[l]) begin
        lane[l] = (mp[l] >= qfrm_pkg::SCL_W'(32768)) ? -16'sd32768
                                                     : qfrm_pkg::OUT_W'(-mp[l]);
      end else begin
        lane[l] = (mp[l] > qfrm_pkg::SCL_W'(32767)) ? 16'sd32767
                                                    : qfrm_pkg::OUT_W'(mp[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_w     <= lane[0];
      quat_x     <= lane[1];
      quat_y     <= lane[2];
      quat_z     <= lane[3];
      degenerate <= mdeg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mvld;
    end
  end

  // A degenerate word carries all zero components.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
    else $error("degenerate word with nonzero component");

  // A nonzero root puts a positive half root into one slot.
  a_half_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> quat_w > 0 || quat_x > 0 || quat_y > 0 || quat_z > 0)
    else $error("no positive component on a regular word");

  // The trace path never reaches a zero root.
  a_trace_root: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] && pipe[NST-1].root == '0 |-> pipe[NST-1].diag)
    else $error("zero root on the trace path");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the rotation matrix to quaternion unit: random and directed matrices, scoreboard check.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 900;
  localparam int LATENCY  = qfrm_pkg::NST + 2;

  // One expected quaternion.
  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               degen;
  } quat_s;

  // Scoreboard: predict the quaternion of each accepted matrix, check results in order.
  class quat_scoreboard;
    quat_s pending[$];
    int    mismatches;

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else begin
          res >>= 1;
        end
        bit_w >>= 2;
      end
      return res;
    endfunction

    function automatic longint unsigned root_of(longint rad);
      if (rad < 0) rad = 0;
      return int_sqrt(longint'(rad) << qfrm_pkg::FRAC_BITS);
    endfunction

    function automatic longint scaled(longint d, longint unsigned r);
      longint unsigned mag, p;
      mag = (d < 0) ? longint'(-d) : d;
      p = (mag * r) >> qfrm_pkg::FRAC_BITS;
      if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
      return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function automatic void note_matrix(logic signed [15:0] m[3][3]);
      longint e[3][3];
      longint q[4];
      longint trace, one;
      longint unsigned root, rc;
      int i, j, k;
      quat_s r;
      one = longint'(1) << qfrm_pkg::FRAC_BITS;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) e[a][b] = m[a][b];
      trace = e[0][0] + e[1][1] + e[2][2];
      r.degen = 1'b0;
      if (trace > 0) begin
        root = root_of(trace + one);
        if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
        rc = (root == 0) ? 0 : (64'd1 << (2 * qfrm_pkg::FRAC_BITS - 1)) / root;
        q[3] = longint'(root >> 1);
        q[0] = scaled(e[1][2] - e[2][1], rc);
        q[1] = scaled(e[2][0] - e[0][2], rc);
        q[2] = scaled(e[0][1] - e[1][0], rc);
      end else begin
        // pick the largest diagonal element; ties keep the lower index
        i = 0;
        if (e[1][1] > e[0][0]) i = 1;
        if (e[2][2] > e[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        root = root_of(e[i][i] - (e[j][j] + e[k][k]) + one);
        if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
        if (root == 0) r.degen = 1'b1;
        rc = (root == 0) ? 0 : (64'd1 << (2 * qfrm_pkg::FRAC_BITS - 1)) / root;
        q[i] = longint'(root >> 1);
        q[3] = scaled(e[j][k] - e[k][j], rc);
        q[j] = scaled(e[i][j] + e[j][i], rc);
        q[k] = scaled(e[i][k] + e[k][i], rc);
      end
      r.w = clamp16(q[3]);
      r.x = clamp16(q[0]);
      r.y = clamp16(q[1]);
      r.z = clamp16(q[2]);
      pending.push_back(r);
    endfunction

    function automatic void check_quat(quat_s got);
      quat_s exp_q;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word w=%0d x=%0d y=%0d z=%0d",
                                       got.w, got.x, got.y, got.z);
        return;
      end
      exp_q = pending.pop_front();
      if (got.w !== exp_q.w || got.x !== exp_q.x || got.y !== exp_q.y ||
          got.z !== exp_q.z || got.degen !== exp_q.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d d=%0b, got w=%0d x=%0d y=%0d z=%0d d=%0b",
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degen,
                   got.w, got.x, got.y, got.z, got.degen);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0,
                      m12 = '0, m20 = '0, m21 = '0, m22 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic degenerate;

  quat_scoreboard sb = new();
  bit quiet_tail = 1'b0;  // last part of the run: no idling on either side
  bit hold_off   = 1'b0;  // long receiver stall to fill the pipeline
  bit stim_done  = 1'b0;

  quaternion_from_rotation_matrix_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note each matrix that the block accepts.
  always @(posedge clk) begin
    logic signed [15:0] mat[3][3];
    if (!rst && in_valid && !in_stall) begin
      mat = '{'{m00, m01, m02}, '{m10, m11, m12}, '{m20, m21, m22}};
      sb.note_matrix(mat);
    end
  end

  // Check each quaternion word taken from the block.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_quat('{quat_w, quat_x, quat_y, quat_z, degenerate});
  end

  // Receiver: random stall bursts, a long hold-off on request, none in the tail.
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Present one matrix and hold it until accepted.
  task automatic send_matrix(logic signed [15:0] a[9]);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random matrix: mostly entries within +-1.0, some raw noise over the full range, some near zero.
  task automatic send_random();
    logic signed [15:0] a[9];
    int mode;
    mode = $urandom_range(0, 9);
    for (int t = 0; t < 9; t++) begin
      if (mode < 6) a[t] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      else if (mode < 8) a[t] = 16'($urandom_range(0, 65535));
      else a[t] = $signed(16'($urandom_range(0, 64))) - 16'sd32;
    end
    // bias the diagonal to exercise each path and each pivot
    if (mode == 3) a[0] = -16'sd16384;
    if (mode == 4) begin a[4] = 16'sd16384; a[0] = -16'sd8000; end
    if (mode == 5) begin a[8] = 16'sd16384; a[0] = -16'sd8000; a[4] = -16'sd8000; end
    send_matrix(a);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity and half-turns about each axis.
    send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    // trace exactly zero takes the diagonal path
    send_matrix('{0, 16384, 0, 0, 0, 16384, 16384, 0, 0});
    // ties on the diagonal keep the lower index
    send_matrix('{0, 100, -200, 300, 0, 50, -70, 90, -5});
    send_matrix('{-5, 100, -200, 300, 7, 50, -70, 90, 7});
    // negative diagonal entries on the diagonal path; the radicand stays nonzero
    send_matrix('{-32768, 1, 2, 3, 16384, 4, 5, 6, 16384});
    send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 0});
    // field extremes, all-zero and all-ones patterns, saturation
    send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    send_matrix('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
    send_matrix('{-1, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 32767});
    send_matrix('{1, 32767, -32768, -32768, 0, 32767, -32768, 32767, 0});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_matrix('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, -32767});

    // Long receiver hold-off while the sender keeps offering words.
    hold_off = 1'b1;
    for (int n = 0; n < 2 * LATENCY; n++) send_random();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 150) quiet_tail = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: wait until every expected word is checked, then settle and report.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
